/* rtl/psd_pkg.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared event codes, the packet descriptor and a helper function.
// ---------------------------------------------------------------------------
package psd_pkg;

    // Event kinds carried on the result channel.
    localparam logic [1:0] KIND_MOVE = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    // Controller status bits that qualify a byte.
    localparam int STAT_READY_BIT = 0;
    localparam int STAT_AUX_BIT   = 5;

    // Packet header layout.
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int BTN_BITS      = 3;

    // Byte slots within a packet.
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_XBYTE  = 2'd1;
    localparam logic [1:0] POS_YBYTE  = 2'd2;

    // Depth of the descriptor queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One decoded packet: the work the back end has to serialize.
    typedef struct packed {
        logic                  move;
        logic signed [8:0]     dx;
        logic signed [9:0]     dy;
        logic [BTN_BITS-1:0]   press;
        logic [BTN_BITS-1:0]   release_m;
    } t_pkt;

    // Index of the single set bit in a one-hot button vector.
    function automatic logic [1:0] f_btn_index(input logic [BTN_BITS-1:0] onehot);
        logic [1:0] idx;
        idx = 2'd0;
        if (onehot[1]) begin
            idx = 2'd1;
        end
        if (onehot[2]) begin
            idx = 2'd2;
        end
        return idx;
    endfunction

endpackage

/* rtl/psd_if.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder channel interfaces
// Valid/ready channels for controller bytes in and mouse events out.
// ---------------------------------------------------------------------------
interface psd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] data_byte;

    modport source (output valid, output status_byte, output data_byte, input ready);
    modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

interface psd_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
    logic [1:0]        button_index;
    logic              last;

    modport source (output valid, output event_kind, output delta_x, output delta_y,
                    output button_index, output last, input ready);
    modport sink   (input valid, input event_kind, input delta_x, input delta_y,
                    input button_index, input last, output ready);
endinterface

/* rtl/psd_front.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder front end
// Filters controller bytes, assembles packets and builds event descriptors.
// ---------------------------------------------------------------------------
module psd_front import psd_pkg::*; #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psd_in_if.sink       i_in,
    input  logic         i_q_full,
    output logic         o_push,
    output t_pkt         o_pkt
);

    localparam logic [BTN_BITS-1:0] BTN_MASK = BTN_BITS'((1 << BUTTON_COUNT) - 1);

    logic [1:0]          r_pos;
    logic [7:0]          r_hdr;
    logic [7:0]          r_xb;
    logic [BTN_BITS-1:0] r_btn;

    logic                take;
    logic                third;
    logic [BTN_BITS-1:0] btn_new;
    logic [BTN_BITS-1:0] changed;

    // A transaction is taken whenever the queue has room.
    assign i_in.ready = !i_q_full;
    assign take = i_in.valid && i_in.ready && i_in.status_byte[STAT_READY_BIT]
                  && i_in.status_byte[STAT_AUX_BIT];
    assign third = take && (r_pos != POS_HEADER) && (r_pos != POS_XBYTE);

    // Decode a completed packet from the stored header, x byte and incoming y byte.
    always_comb begin
        btn_new           = r_hdr[BTN_BITS-1:0];
        changed           = (btn_new ^ r_btn) & BTN_MASK;
        o_pkt.move        = (r_xb != 8'd0) || (i_in.data_byte != 8'd0);
        o_pkt.dx          = {r_hdr[HDR_XSIGN_BIT], r_xb};
        o_pkt.dy          = 10'sd0 - {r_hdr[HDR_YSIGN_BIT], r_hdr[HDR_YSIGN_BIT],
                                      i_in.data_byte};
        o_pkt.press       = changed & btn_new;
        o_pkt.release_m   = changed & r_btn;
        o_push            = third && (o_pkt.move || (changed != '0));
    end

    // Packet position and stored buttons.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HEADER;
            r_btn <= '0;
        end else if (take) begin
            unique case (r_pos)
                POS_HEADER: r_pos <= POS_XBYTE;
                POS_XBYTE:  r_pos <= POS_YBYTE;
                default: begin
                    r_pos <= POS_HEADER;
                    r_btn <= btn_new;
                end
            endcase
        end
    end

    // Packet bytes need no reset.
    always_ff @(posedge i_clk) begin
        if (take && (r_pos == POS_HEADER)) begin
            r_hdr <= i_in.data_byte;
        end
        if (take && (r_pos == POS_XBYTE)) begin
            r_xb <= i_in.data_byte;
        end
    end

    // The position counter only walks through the three byte slots.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_YBYTE) else $error("packet position out of range");

    // A push never asks a button to go down and up at once.
    a_push_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> ((o_pkt.press & o_pkt.release_m) == '0))
        else $error("button both pressed and released");

endmodule

/* rtl/psd_queue.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder descriptor queue
// Small FIFO that decouples packet decode from event serialization.
// ---------------------------------------------------------------------------
module psd_queue import psd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_pkt o_pkt
);

    t_pkt           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_pkt   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    // Descriptor storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("descriptor queue underflow");

endmodule

/* rtl/psd_back.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder back end
// Serializes a descriptor into move and button events, one per cycle if ready.
// ---------------------------------------------------------------------------
module psd_back import psd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_pkt       i_q_pkt,
    output logic       o_pop,
    psd_out_if.source  o_out
);

    logic                r_busy;
    logic                r_mv;
    logic signed [8:0]   r_dx;
    logic signed [9:0]   r_dy;
    logic [BTN_BITS-1:0] r_pr;
    logic [BTN_BITS-1:0] r_rl;

    logic                r_ovld;
    logic [1:0]          r_kind;
    logic signed [8:0]   r_odx;
    logic signed [9:0]   r_ody;
    logic [1:0]          r_idx;
    logic                r_last;

    logic                emit;
    logic [BTN_BITS-1:0] pend;
    logic [BTN_BITS-1:0] sel;
    logic                ev_last;
    logic [1:0]          ev_kind;

    // Pick the next event: motion first, then buttons in ascending order.
    always_comb begin
        pend = r_pr | r_rl;
        sel  = pend & (~pend + 1'b1);
        if (r_mv) begin
            ev_kind = KIND_MOVE;
            ev_last = (pend == '0);
        end else begin
            ev_kind = ((sel & r_pr) != '0) ? KIND_DOWN : KIND_UP;
            ev_last = ((pend & ~sel) == '0);
        end
    end

    assign emit  = r_busy && (!r_ovld || o_out.ready);
    assign o_pop = i_q_valid && (!r_busy || (emit && ev_last));

    // Working descriptor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && ev_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mv <= i_q_pkt.move;
            r_dx <= i_q_pkt.dx;
            r_dy <= i_q_pkt.dy;
            r_pr <= i_q_pkt.press;
            r_rl <= i_q_pkt.release_m;
        end else if (emit) begin
            if (r_mv) begin
                r_mv <= 1'b0;
            end else begin
                r_pr <= r_pr & ~sel;
                r_rl <= r_rl & ~sel;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (emit) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= ev_kind;
            r_last <= ev_last;
            r_odx  <= r_mv ? r_dx : 9'sd0;
            r_ody  <= r_mv ? r_dy : 10'sd0;
            r_idx  <= r_mv ? 2'd0 : f_btn_index(sel);
        end
    end

    assign o_out.valid        = r_ovld;
    assign o_out.event_kind   = r_kind;
    assign o_out.delta_x      = r_odx;
    assign o_out.delta_y      = r_ody;
    assign o_out.button_index = r_idx;
    assign o_out.last         = r_last;

    // A busy working slot always has at least one event left.
    a_busy_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mv || (pend != '0))) else $error("busy with no pending event");

    // Button events never carry motion.
    a_btn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_kind != KIND_MOVE)) |-> ((r_odx == 9'sd0) && (r_ody == 10'sd0)))
        else $error("button event with nonzero delta");

endmodule

/* rtl/ps2_mouse_packet_decoder.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Turns controller status/data byte pairs into move and button events.
// ---------------------------------------------------------------------------
// A packet's first event passes the descriptor queue, the working descriptor and
// the output register. Throughput: one byte per cycle in; one event per cycle
// out while the receiver is ready, up to four per packet, serialized by the back
// end from a two-entry descriptor queue. Input ready drops only while it is full.
// Reset is synchronous and active low; it clears the packet position, the stored
// buttons and all valid flags. No memory clearing pass is needed.
module ps2_mouse_packet_decoder import psd_pkg::*; #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psd_in_if.sink     i_in,
    psd_out_if.source  o_out
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_pkt push_pkt;
    t_pkt head_pkt;

    // Packet assembly and classification.
    psd_front #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_pkt    (push_pkt)
    );

    // Descriptor queue.
    psd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_pkt   (head_pkt)
    );

    // Event serialization.
    psd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_pkt   (head_pkt),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* tb/tb_ps2_mouse_packet_decoder.sv */
// ---------------------------------------------------------------------------
// Testbench for the PS/2 mouse packet decoder
// Drives controller status/data pairs, predicts the mouse events each packet
// causes and checks every event transaction on the output channel in order.
// ---------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder import psd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUTTON_COUNT = 3;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int IDLE_PERCENT = 8;

    // Status value that qualifies a byte as coming from the mouse.
    localparam logic [7:0] STATUS_AUX_READY =
        (8'd1 << STAT_READY_BIT) | (8'd1 << STAT_AUX_BIT);

    // One mouse event as it appears on the output channel.
    typedef struct {
        logic [1:0]        kind;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic [1:0]        btn;
        logic              last;
    } t_mouse_event;

    logic i_clk;
    logic i_rst_n;

    psd_in_if  in_ch ();
    psd_out_if out_ch ();

    ps2_mouse_packet_decoder #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Decoder state as the testbench tracks it.
    logic [1:0]          pkt_pos      = POS_HEADER;
    logic [7:0]          pkt_hdr      = 8'd0;
    logic [7:0]          pkt_x        = 8'd0;
    logic [BTN_BITS-1:0] held_buttons = '0;

    t_mouse_event pending_events[$];
    int           err_count = 0;
    int           cycles    = 0;
    bit           calm      = 1'b0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = ~i_clk;
    end

    // Every input of the block has a known value from time zero.
    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.status_byte  = 8'd0;
        in_ch.data_byte    = 8'd0;
        out_ch.ready       = 1'b0;
    end

    // The event receiver stalls now and then, except during the calm stretch.
    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d events outstanding", $time,
                     pending_events.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic bit status_ok(logic [7:0] status);
        return status[STAT_READY_BIT] && status[STAT_AUX_BIT];
    endfunction

    // Advances the packet state by one byte and queues the events it causes.
    function automatic void decode_byte(logic [7:0] status, logic [7:0] data);
        t_mouse_event        ev;
        logic signed [9:0]   y_ext;
        logic [BTN_BITS-1:0] now_btn;
        bit                  moved;
        int                  total;
        int                  k;

        if (!status_ok(status)) begin
            return;
        end
        if (pkt_pos == POS_HEADER) begin
            pkt_hdr = data;
            pkt_pos = POS_XBYTE;
            return;
        end
        if (pkt_pos == POS_XBYTE) begin
            pkt_x   = data;
            pkt_pos = POS_YBYTE;
            return;
        end

        pkt_pos = POS_HEADER;
        now_btn = pkt_hdr[BTN_BITS-1:0];
        moved   = (pkt_x != 8'd0) || (data != 8'd0);

        // Count the events first so the final one can carry the last flag.
        total = moved ? 1 : 0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (now_btn[i] != held_buttons[i]) begin
                total++;
            end
        end

        k = 0;
        if (moved) begin
            k++;
            ev.kind = KIND_MOVE;
            ev.dx   = {pkt_hdr[HDR_XSIGN_BIT], pkt_x};
            y_ext   = {{2{pkt_hdr[HDR_YSIGN_BIT]}}, data};
            ev.dy   = -y_ext;
            ev.btn  = 2'd0;
            ev.last = (k == total);
            pending_events.push_back(ev);
        end

        // Button changes follow in ascending button order.
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (now_btn[i] != held_buttons[i]) begin
                k++;
                ev.kind = now_btn[i] ? KIND_DOWN : KIND_UP;
                ev.dx   = '0;
                ev.dy   = '0;
                ev.btn  = i[1:0];
                ev.last = (k == total);
                pending_events.push_back(ev);
            end
        end
        held_buttons = now_btn;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Compares every event transaction with the oldest expected event.
    always @(posedge i_clk) begin
        t_mouse_event want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event: expected none, actual kind %0d dx %0d dy %0d",
                         $time, out_ch.event_kind, out_ch.delta_x, out_ch.delta_y);
                err_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", int'(want.kind), int'(out_ch.event_kind));
                check_field("delta_x", int'(want.dx), int'(out_ch.delta_x));
                check_field("delta_y", int'(want.dy), int'(out_ch.delta_y));
                check_field("button_index", int'(want.btn), int'(out_ch.button_index));
                check_field("last", int'(want.last), int'(out_ch.last));
            end
        end
    end

    // Offers one byte pair and returns at the edge that accepts it, with valid
    // still high so the next call can follow without a gap.
    task automatic send_byte(logic [7:0] status, logic [7:0] data);
        if (!calm && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.status_byte <= status;
        in_ch.data_byte   <= data;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        decode_byte(status, data);
    endtask

    task automatic send_packet(logic [7:0] hdr, logic [7:0] xb, logic [7:0] yb);
        send_byte(STATUS_AUX_READY, hdr);
        send_byte(STATUS_AUX_READY, xb);
        send_byte(STATUS_AUX_READY, yb);
    endtask

    task automatic drain_events();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random header and deltas, with zero deltas frequent enough to matter.
    task automatic send_random_packet(output int sent);
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
        hdr = 8'($urandom_range(0, 255));
        xb  = ($urandom_range(0, 99) < 25) ? 8'd0 : 8'($urandom_range(0, 255));
        yb  = ($urandom_range(0, 99) < 25) ? 8'd0 : 8'($urandom_range(0, 255));
        send_byte(8'($urandom_range(0, 255)) | STATUS_AUX_READY, hdr);
        send_byte(8'($urandom_range(0, 255)) | STATUS_AUX_READY, xb);
        send_byte(8'($urandom_range(0, 255)) | STATUS_AUX_READY, yb);
        sent = 3;
    endtask

    // Extremes of both deltas, every event kind, ignored bytes and flag bits.
    task automatic test_directed();
        send_byte(8'h00, 8'h55);
        send_byte(8'h01, 8'hAA);
        send_byte(8'h20, 8'hFF);
        // No motion and no button change: nothing comes out.
        send_packet(8'h08, 8'h00, 8'h00);
        // Most negative x with a press of the first button.
        send_packet(8'h19, 8'h00, 8'h01);
        // Most positive x, most negative y, one release and two presses.
        send_byte(8'hFF, 8'h0E);
        send_byte(STATUS_AUX_READY, 8'hFF);
        send_byte(STATUS_AUX_READY, 8'hFF);
        // A sign bit alone is no motion; two releases.
        send_packet(8'h28, 8'h00, 8'h00);
        // Overflow bits set, bit 3 clear, largest y, all three pressed.
        send_packet(8'hE7, 8'h80, 8'h00);
        send_packet(8'hC7, 8'h00, 8'h00);
        // Stray bytes inside a packet leave it intact.
        send_byte(STATUS_AUX_READY, 8'h10);
        send_byte(8'hDE, 8'h33);
        send_byte(STATUS_AUX_READY, 8'h7F);
        send_byte(8'h1F, 8'hCC);
        send_byte(8'hE0, 8'h44);
        send_byte(STATUS_AUX_READY, 8'h80);
    endtask

    // Hold the sender back until every event has left the block.
    task automatic test_pause_until_drained();
        send_packet(8'h0F, 8'h12, 8'hF0);
        drain_events();
        send_packet(8'h08, 8'h01, 8'h00);
        drain_events();
    endtask

    // Mostly well-formed packets with some noise and misaligning stray bytes.
    task automatic test_random_traffic(int target);
        int         counted;
        int         sent;
        logic [7:0] status;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(0, 99) < 85) begin
                send_random_packet(sent);
                counted += sent;
            end else begin
                status = 8'($urandom_range(0, 255));
                send_byte(status, 8'($urandom_range(0, 255)));
                if (status_ok(status)) begin
                    counted++;
                end
            end
        end
    endtask

    // A stretch with neither side idling, so events leave back to back.
    task automatic test_back_to_back(int packets);
        int sent;
        calm = 1'b1;
        for (int p = 0; p < packets; p++) begin
            send_random_packet(sent);
        end
        calm = 1'b0;
    endtask

    // Test sequence.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pause_until_drained();
        test_random_traffic(100);
        test_back_to_back(20);
        test_random_traffic(20);

        drain_events();
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
